[hw/rtl/pctb_pkg.sv]
// Package for the per-client token bucket limiter: payload structs, FSM states,
// register indexes and defaults. No dependencies.
`timescale 1ns / 1ps
package pctb_pkg;

  localparam int TableEntriesDefault = 1024;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth = 32;

  localparam logic [CfgIndexWidth-1:0] RegBucketSize = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegRefillRate = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegEntryTtl   = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegMaxEntries = 2'd3;

  localparam logic [15:0] BucketSizeReset = 16'd10;
  localparam logic [31:0] RefillRateReset = 32'd66;
  localparam logic [31:0] EntryTtlReset   = 32'd300000;
  localparam logic [10:0] MaxEntriesReset = 11'd1024;

  localparam logic [31:0] OneToken = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] client_addr;
    logic [31:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic allowed;
    logic table_full;
  } resp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_READ,
    ST_UPDATE,
    ST_MULT,
    ST_WRITE
  } state_t;

endpackage

[hw/rtl/per_client_token_bucket_limiter_core.sv]
// Top level of the per-client token bucket limiter.
// Depends on pctb_pkg for payload types, register codes and FSM states.
// Requests are taken one at a time: input stalls until the result is loaded. A prune-and-search
// walk reads every slot of the entry memory once per request; the found or new entry is then
// read, refilled and written back, while a table-full denial skips that update.
// Reset clears live count and registers, then a clearing pass marks every slot of the valid
// memory free with input stalled. A finished result waits in the output register while
// the next request is taken; a result still stalled at the next finish holds the block.
`timescale 1ns / 1ps
module per_client_token_bucket_limiter_core #(
  parameter int TABLE_ENTRIES = pctb_pkg::TableEntriesDefault
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pctb_pkg::req_t                     in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pctb_pkg::resp_t                    out_data,
  input  logic                               cfg_we,
  input  logic [pctb_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [pctb_pkg::CfgDataWidth-1:0]  cfg_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW:0] LastIdx = (IW + 1)'(TABLE_ENTRIES - 1);
  localparam logic [IW-1:0] ClrLast = IW'(TABLE_ENTRIES - 1);

  // Configuration registers.
  logic [15:0] bucket_size;
  logic [31:0] refill_rate;
  logic [31:0] entry_ttl;
  logic [10:0] max_entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_size <= pctb_pkg::BucketSizeReset;
      refill_rate <= pctb_pkg::RefillRateReset;
      entry_ttl   <= pctb_pkg::EntryTtlReset;
      max_entries <= pctb_pkg::MaxEntriesReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pctb_pkg::RegBucketSize: bucket_size <= cfg_data[15:0];
        pctb_pkg::RegRefillRate: refill_rate <= cfg_data;
        pctb_pkg::RegEntryTtl:   entry_ttl   <= cfg_data;
        pctb_pkg::RegMaxEntries: max_entries <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Entry memories: valid, key and last seen for the walk, tokens and last
  // refill for the update.
  logic [31:0] mem_key  [TABLE_ENTRIES];
  logic [31:0] mem_seen [TABLE_ENTRIES];
  logic [31:0] mem_tok  [TABLE_ENTRIES];
  logic [31:0] mem_ref  [TABLE_ENTRIES];
  logic        mem_valid [TABLE_ENTRIES];

  pctb_pkg::state_t state, state_next;
  pctb_pkg::req_t   req;
  logic [IW:0]  scan_idx;
  logic [IW-1:0] rd_idx_q;
  logic          rd_pending;
  logic [31:0]  rd_key, rd_seen, rd_tok, rd_ref;
  logic          rd_valid;
  logic          found, free_seen;
  logic [IW-1:0] found_idx, free_idx;
  logic [CW-1:0] live_count;
  logic          is_new;
  logic [31:0]  tok, last_ref;
  logic [31:0]  elapsed;
  logic [63:0]  refill;
  logic          res_pending;
  pctb_pkg::resp_t res;
  logic          clearing;
  logic [IW-1:0] clr_idx;

  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [31:0]  wr_tok;
  logic          allow;
  logic [31:0]  cap;
  logic [31:0]  seen_age;
  logic          expire;
  logic          at_cap;
  logic          deny_full;
  logic          out_free;
  logic          res_load;
  logic          vld_we;
  logic [IW-1:0] vld_addr;
  logic          vld_din;

  assign cap = {bucket_size, 16'h0000};
  assign rd_addr = (state == pctb_pkg::ST_READ) ? found_idx : scan_idx[IW-1:0];

  always_ff @(posedge clk) begin
    rd_key   <= mem_key[rd_addr];
    rd_seen  <= mem_seen[rd_addr];
    rd_tok   <= mem_tok[rd_addr];
    rd_ref   <= mem_ref[rd_addr];
    rd_valid <= mem_valid[rd_addr];
  end

  // Refill and consume on the chosen entry, from registered product.
  logic [31:0] after_refill;
  always_comb begin
    after_refill = tok;
    if (refill != 64'd0) begin
      if (tok >= cap || refill >= {32'd0, cap - tok}) after_refill = cap;
      else after_refill = tok + refill[31:0];
    end
    allow  = after_refill >= pctb_pkg::OneToken;
    wr_tok = allow ? after_refill - pctb_pkg::OneToken : after_refill;
  end

  // The output register is free when empty or handing its result over now.
  assign out_free = !res_pending || !out_stall;
  assign at_cap = 32'(live_count) >= 32'(max_entries);
  assign deny_full = !found && (at_cap || !free_seen);
  assign res_load = out_free && ((state == pctb_pkg::ST_DECIDE && deny_full)
                                 || state == pctb_pkg::ST_WRITE);
  assign wr_en = (state == pctb_pkg::ST_WRITE) && out_free;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_tok[found_idx]  <= wr_tok;
      mem_ref[found_idx]  <= (refill != 64'd0) ? req.now_ticks : last_ref;
      mem_seen[found_idx] <= req.now_ticks;
      mem_key[found_idx]  <= req.client_addr;
    end
  end

  // Age of the entry read during the walk.
  assign seen_age = (req.now_ticks > rd_seen) ? req.now_ticks - rd_seen : 32'd0;
  assign expire   = rd_pending && rd_valid && (seen_age > entry_ttl);

  // Valid write port: clearing pass, pruning during the walk, or a new entry.
  always_comb begin
    vld_we   = 1'b0;
    vld_addr = rd_idx_q;
    vld_din  = 1'b0;
    if (clearing) begin
      vld_we   = 1'b1;
      vld_addr = clr_idx;
    end else if (expire) begin
      vld_we   = 1'b1;
    end else if (state == pctb_pkg::ST_DECIDE && !found && !deny_full) begin
      vld_we   = 1'b1;
      vld_addr = free_idx;
      vld_din  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_we) mem_valid[vld_addr] <= vld_din;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pctb_pkg::ST_IDLE:   if (in_valid && !in_stall) state_next = pctb_pkg::ST_SCAN;
      pctb_pkg::ST_SCAN:   if (scan_idx == LastIdx) state_next = pctb_pkg::ST_DRAIN;
      pctb_pkg::ST_DRAIN:  state_next = pctb_pkg::ST_DECIDE;
      pctb_pkg::ST_DECIDE: begin
        if (deny_full) begin
          if (out_free) state_next = pctb_pkg::ST_IDLE;
        end else state_next = pctb_pkg::ST_READ;
      end
      pctb_pkg::ST_READ:   state_next = pctb_pkg::ST_UPDATE;
      pctb_pkg::ST_UPDATE: state_next = pctb_pkg::ST_MULT;
      pctb_pkg::ST_MULT:   state_next = pctb_pkg::ST_WRITE;
      pctb_pkg::ST_WRITE:  if (out_free) state_next = pctb_pkg::ST_IDLE;
      default:             state_next = pctb_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = (state != pctb_pkg::ST_IDLE) || clearing;
    out_valid = res_pending;
    out_data  = res;
  end

  // Datapath and bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pctb_pkg::ST_IDLE;
      live_count  <= '0;
      res_pending <= 1'b0;
      rd_pending  <= 1'b0;
      scan_idx    <= '0;
      clearing    <= 1'b1;
      clr_idx     <= '0;
    end else begin
      state <= state_next;
      res_pending <= res_load || (res_pending && out_stall);
      if (res_load) begin
        res <= '{allowed: (state == pctb_pkg::ST_WRITE) && allow,
                 table_full: state != pctb_pkg::ST_WRITE};
      end
      if (clearing) begin
        clr_idx <= clr_idx + IW'(1);
        if (clr_idx == ClrLast) clearing <= 1'b0;
      end
      rd_pending <= (state == pctb_pkg::ST_SCAN);
      rd_idx_q   <= scan_idx[IW-1:0];
      if (expire && live_count != '0) live_count <= live_count - CW'(1);
      unique case (state)
        pctb_pkg::ST_IDLE: begin
          scan_idx  <= '0;
          found     <= 1'b0;
          free_seen <= 1'b0;
          if (in_valid && !in_stall) req <= in_data;
        end
        pctb_pkg::ST_SCAN: scan_idx <= scan_idx + (IW + 1)'(1);
        pctb_pkg::ST_DECIDE: begin
          is_new <= !found;
          if (!found) found_idx <= free_idx;
          if (!found && !deny_full) live_count <= live_count + CW'(1);
        end
        pctb_pkg::ST_UPDATE: begin
          tok      <= is_new ? cap : rd_tok;
          last_ref <= is_new ? req.now_ticks : rd_ref;
          elapsed  <= (!is_new && req.now_ticks > rd_ref) ? req.now_ticks - rd_ref : 32'd0;
        end
        pctb_pkg::ST_MULT: refill <= {32'd0, elapsed} * {32'd0, refill_rate};
        default: ;
      endcase
      // Search runs on the data of the walk, after pruning of the same slot.
      if (rd_pending) begin
        if (rd_valid && !expire) begin
          if (!found && rd_key == req.client_addr) begin
            found     <= 1'b1;
            found_idx <= rd_idx_q;
          end
        end else if (!free_seen) begin
          free_seen <= 1'b1;
          free_idx  <= rd_idx_q;
        end
      end
    end
  end

  // A result is never raised while another still waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_pending && out_stall |=> res_pending && $stable(res))
    else $error("pending result overwritten");
  // Live count never exceeds the table.
  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, live_count} <= (CW + 1)'(TABLE_ENTRIES))
    else $error("live count out of range");
  // A table-full result never reports allowed.
  a_full_denies: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.allowed && out_data.table_full))
    else $error("allowed with table full");
  // No request is taken while the valid memory is being cleared.
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall)
    else $error("request taken during clearing pass");

endmodule
